/* sv/fbsc_pkg.sv */
package fbsc_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int NORMAL_BITS = 12;
	localparam int W_BITS = 28;
	localparam int W_SHIFT = 36;
	localparam int FRAC_SHIFT = 10;
	localparam int PLANE_BITS = 64;
	localparam int CFG_INDEX_BITS = 3;
	localparam int FLAG_BITS = 8;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SHAPE_MODE = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FLAG_BIT = 3'd7;

	// plane word: nx [11:0], ny [23:12], nz [35:24], w [63:36]
	typedef logic [PLANE_BITS-1:0] plane_t;

	typedef struct packed {
		plane_t [PLANE_COUNT-1:0] plane;
		logic shape_mode;
		logic [2:0] flag_bit;
	} cfg_t;

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} stage_en_t;

endpackage

/* sv/fbsc_cfg_regs.sv */
module fbsc_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [fbsc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [fbsc_pkg::PLANE_BITS-1:0] cfg_data,
	output fbsc_pkg::cfg_t cfg
);

	fbsc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fbsc_pkg::REG_SHAPE_MODE: cfg_q.shape_mode <= cfg_data[0];
				fbsc_pkg::REG_FLAG_BIT:   cfg_q.flag_bit <= cfg_data[2:0];
				default:                  cfg_q.plane[cfg_index] <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/fbsc_plane_dp.sv */
module fbsc_plane_dp #(
	parameter int COORD_BITS = 24
) (
	input  logic clk,
	input  fbsc_pkg::stage_en_t en,
	input  fbsc_pkg::plane_t plane,
	input  logic shape_mode,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic signed [COORD_BITS-1:0] center_z,
	input  logic [COORD_BITS-2:0] extent_x,
	input  logic [COORD_BITS-2:0] extent_y,
	input  logic [COORD_BITS-2:0] extent_z,
	output logic neg_s3
);

	localparam int NB = fbsc_pkg::NORMAL_BITS;
	localparam int PW = COORD_BITS + NB;
	localparam int EW = COORD_BITS + NB - 1;
	localparam int WW = fbsc_pkg::W_BITS + fbsc_pkg::FRAC_SHIFT;
	localparam int SW = ((PW > WW) ? PW : WW) + 3;

	logic signed [NB-1:0] nx, ny, nz;
	logic [NB-1:0] anx, any_n, anz;
	logic signed [fbsc_pkg::W_BITS-1:0] w;
	logic signed [SW-1:0] w_term;

	logic signed [PW-1:0] pcx_s1, pcy_s1, pcz_s1;
	logic [EW-1:0] pex_s1, pey_s1, pez_s1;
	logic signed [SW-1:0] sumc_s2, sume_s2, d;

	assign nx = $signed(plane[NB-1:0]);
	assign ny = $signed(plane[2*NB-1:NB]);
	assign nz = $signed(plane[3*NB-1:2*NB]);
	assign w = $signed(plane[fbsc_pkg::PLANE_BITS-1:fbsc_pkg::W_SHIFT]);

	// magnitude of the most negative normal still fits as unsigned
	assign anx = nx[NB-1] ? NB'(-nx) : NB'(nx);
	assign any_n = ny[NB-1] ? NB'(-ny) : NB'(ny);
	assign anz = nz[NB-1] ? NB'(-nz) : NB'(nz);

	assign w_term = $signed(SW'(w)) <<< fbsc_pkg::FRAC_SHIFT;

	always_ff @(posedge clk) begin
		if (en.en1) begin
			pcx_s1 <= PW'(nx) * PW'(center_x);
			pcy_s1 <= PW'(ny) * PW'(center_y);
			pcz_s1 <= PW'(nz) * PW'(center_z);
			if (shape_mode) begin
				// radius aligned to the product fraction
				pex_s1 <= EW'({extent_x, {fbsc_pkg::FRAC_SHIFT{1'b0}}});
				pey_s1 <= '0;
				pez_s1 <= '0;
			end else begin
				pex_s1 <= EW'(anx) * EW'(extent_x);
				pey_s1 <= EW'(any_n) * EW'(extent_y);
				pez_s1 <= EW'(anz) * EW'(extent_z);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.en2) begin
			sumc_s2 <= SW'(pcx_s1) + SW'(pcy_s1) + SW'(pcz_s1) + w_term;
			sume_s2 <= $signed(SW'(pex_s1) + SW'(pey_s1) + SW'(pez_s1));
		end
	end

	assign d = sumc_s2 - sume_s2;

	always_ff @(posedge clk) begin
		if (en.en3) begin
			neg_s3 <= d[SW-1];
		end
	end

endmodule

/* sv/frustum_box_sphere_cull.sv */
// Culls boxes or spheres against six frustum planes, one object per clock
// while the master side accepts. An object taken on the slave stream passes
// the multiply, sum, subtract/sign and output registers in turn before its
// result appears on the master stream; a stall on the master side holds the
// pipeline in place and only fills empty stages, so no object is lost or
// repeated. An object is visible only when every plane value is strictly
// negative. Box mode writes the visible flag into bit flag_bit of
// prior_flags; sphere mode (radius in extent_x) returns it alone in bit 0.
// Write the planes and mode only while no object is in flight; after reset
// all planes are zero and nothing is visible.
module frustum_box_sphere_cull #(
	parameter int COORD_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [fbsc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [fbsc_pkg::PLANE_BITS-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// center_x, center_y, center_z, extent_x, extent_y, extent_z, prior_flags, zero fill
	input  logic [((6*COORD_BITS+5+7)/8)*8-1:0] s_tdata,
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	// flags, visible, zero fill
	output logic [15:0] m_tdata,
	output logic m_tlast
);

	localparam int CB = COORD_BITS;
	localparam int EB = COORD_BITS - 1;
	localparam int PC = fbsc_pkg::PLANE_COUNT;
	localparam int FB = fbsc_pkg::FLAG_BITS;

	fbsc_pkg::cfg_t cfg;
	fbsc_pkg::stage_en_t en;

	logic signed [CB-1:0] cx, cy, cz;
	logic [EB-1:0] ex, ey, ez;
	logic [FB-1:0] prior_in;

	logic v1_s1, v2_s2, v3_s3, vo_q;
	logic rdy1, rdy2, rdy3, rdyo;
	logic [FB-1:0] prior_s1, prior_s2, prior_s3;
	logic last_s1, last_s2, last_s3;
	logic [PC-1:0] neg_s3;
	logic vis;
	logic [FB-1:0] flags_next;
	logic [FB-1:0] flags_q;
	logic visible_q, last_q;

	assign cx = $signed(s_tdata[CB-1:0]);
	assign cy = $signed(s_tdata[2*CB-1:CB]);
	assign cz = $signed(s_tdata[3*CB-1:2*CB]);
	assign ex = s_tdata[3*CB+EB-1:3*CB];
	assign ey = s_tdata[3*CB+2*EB-1:3*CB+EB];
	assign ez = s_tdata[3*CB+3*EB-1:3*CB+2*EB];
	assign prior_in = s_tdata[3*CB+3*EB+FB-1:3*CB+3*EB];

	fbsc_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	// a stage advances when it is empty or the next one advances
	assign rdyo = !vo_q || m_tready;
	assign rdy3 = !v3_s3 || rdyo;
	assign rdy2 = !v2_s2 || rdy3;
	assign rdy1 = !v1_s1 || rdy2;
	assign s_tready = rdy1;

	assign en.en1 = rdy1 && s_tvalid;
	assign en.en2 = rdy2 && v1_s1;
	assign en.en3 = rdy3 && v2_s2;

	for (genvar j = 0; j < PC; j++) begin : g_plane
		fbsc_plane_dp #(
			.COORD_BITS(COORD_BITS)
		) u_plane (
			.clk(clk),
			.en(en),
			.plane(cfg.plane[j]),
			.shape_mode(cfg.shape_mode),
			.center_x(cx),
			.center_y(cy),
			.center_z(cz),
			.extent_x(ex),
			.extent_y(ey),
			.extent_z(ez),
			.neg_s3(neg_s3[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= s_tvalid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdyo) vo_q <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en1) begin
			prior_s1 <= prior_in;
			last_s1 <= s_tlast;
		end
		if (en.en2) begin
			prior_s2 <= prior_s1;
			last_s2 <= last_s1;
		end
		if (en.en3) begin
			prior_s3 <= prior_s2;
			last_s3 <= last_s2;
		end
	end

	assign vis = &neg_s3;

	always_comb begin
		if (cfg.shape_mode) begin
			flags_next = FB'(vis);
		end else begin
			flags_next = prior_s3;
			flags_next[cfg.flag_bit] = vis;
		end
	end

	always_ff @(posedge clk) begin
		if (rdyo && v3_s3) begin
			flags_q <= flags_next;
			visible_q <= vis;
			last_q <= last_s3;
		end
	end

	assign m_tvalid = vo_q;
	assign m_tdata = {7'b0, visible_q, flags_q};
	assign m_tlast = last_q;

	a_accept_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_s1 |-> s_tready)
		else $error("input stalled with empty first stage");

	a_stage3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v3_s3 && !rdy3 |=> v3_s3 && $stable(neg_s3) && $stable(last_s3))
		else $error("stage 3 lost or changed a held object");

	a_visible_from_planes: assert property (@(posedge clk) disable iff (!arst_n)
		rdyo && v3_s3 |=> visible_q == $past(&neg_s3))
		else $error("visible flag does not match plane results");

endmodule
